/* design/ppgf_pkg.sv */
// ppgf_pkg: widths, register indexes, reset values and types for the ppg filter
// used by ppgf_cell, ppgf_div and ppg_dc_mean_lowpass_filter; no dependencies
package ppgf_pkg;

    localparam int RAW_W     = 18;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int COEF_W    = 16;
    localparam int COEF_FRAC = 16;
    localparam int W_W       = 40;
    localparam int D_W       = 36;
    localparam int V_W       = 36;
    localparam int OUT_W     = 24;
    localparam int EXT_W     = 42;
    localparam int HALF_W    = 20;
    localparam int MUL_A_W   = COEF_W + 1;
    localparam int MUL_B_W   = HALF_W + 1;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int SUM_W     = 58;
    localparam int DIV_STEP  = 4;
    localparam int CNT_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DC_ALPHA       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LP_INPUT_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LP_FEEDBACK    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_DISCARD = 2'd3;

    localparam logic [CFG_W-1:0] RST_DC_ALPHA       = 16'd62259;
    localparam logic [CFG_W-1:0] RST_LP_INPUT_GAIN  = 16'd16072;
    localparam logic [CFG_W-1:0] RST_LP_FEEDBACK    = 16'd33392;
    localparam logic [CFG_W-1:0] RST_WARMUP_DISCARD = 16'd0;

    typedef logic signed [D_W-1:0] t_d;

endpackage

/* design/ppgf_cell.sv */
// ppgf_cell: one slot of the mean window shift line, holds one stage-1 output
// depends on ppgf_pkg
module ppgf_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  ppgf_pkg::t_d  i_data,
    output ppgf_pkg::t_d  o_data
);

    ppgf_pkg::t_d r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

/* design/ppgf_div.sv */
// ppgf_div: iterative signed-by-unsigned divider, several quotient bits per cycle,
// quotient truncated toward zero; depends on ppgf_pkg
module ppgf_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 5
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic        [DEN_W-1:0] i_den,
    output logic                    o_done,
    output logic signed [NUM_W-1:0] o_quot
);

    localparam int STEP   = ppgf_pkg::DIV_STEP;
    localparam int DIV_W  = ((NUM_W + STEP - 1) / STEP) * STEP;
    localparam int ITERS  = DIV_W / STEP;
    localparam int ITER_W = $clog2(ITERS + 1);

    logic              r_busy;
    logic              r_done;
    logic [ITER_W-1:0] r_cnt;
    logic              r_neg;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_quo;

    logic [DEN_W-1:0]  n_rem;
    logic [DIV_W-1:0]  n_quo;
    logic [NUM_W-1:0]  mag_in;
    logic [NUM_W-1:0]  mag_out;

    always_comb begin
        logic [DEN_W:0] trial;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < STEP; k++) begin
            trial = {n_rem, n_quo[DIV_W-1]};
            n_quo = {n_quo[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                n_rem    = DEN_W'(trial - {1'b0, r_den});
                n_quo[0] = 1'b1;
            end else begin
                n_rem = DEN_W'(trial);
            end
        end
    end

    assign mag_in  = i_num[NUM_W-1] ? (~i_num + 1'b1) : i_num;
    assign mag_out = r_quo[NUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ITER_W'(ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[NUM_W-1];
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= DIV_W'(mag_in);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? $signed(~mag_out + 1'b1) : $signed(mag_out);

endmodule

/* design/ppg_dc_mean_lowpass_filter.sv */
// ppg_dc_mean_lowpass_filter: dc removal, window mean difference and low-pass on ppg samples
// arithmetic runs on a shared 17x21 multiplier (six passes) and a 4-bit-per-cycle window divider;
// one item at a time: a new input is taken only when idle, once the last one is output or discarded
// synchronous active-low reset clears the filter state and window cells; config registers take
// their reset values and the payload registers are not reset
// depends on ppgf_pkg, ppgf_cell, ppgf_div
module ppg_dc_mean_lowpass_filter #(
    parameter int MEAN_WINDOW   = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [ppgf_pkg::RAW_W-1:0]            i_raw_sample,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [ppgf_pkg::OUT_W-1:0]     o_filtered_value,
    input  logic                                  i_cfg_we,
    input  logic [ppgf_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [ppgf_pkg::CFG_W-1:0]            i_cfg_data
);

    localparam int W_W     = ppgf_pkg::W_W;
    localparam int D_W     = ppgf_pkg::D_W;
    localparam int V_W     = ppgf_pkg::V_W;
    localparam int EXT_W   = ppgf_pkg::EXT_W;
    localparam int SUM_W   = ppgf_pkg::SUM_W;
    localparam int PROD_W  = ppgf_pkg::PROD_W;
    localparam int HALF_W  = ppgf_pkg::HALF_W;
    localparam int TOTAL_W = D_W + $clog2(MEAN_WINDOW);
    localparam int FILL_W  = $clog2(MEAN_WINDOW + 1);

    localparam logic signed [EXT_W-1:0] ROUND_ADD =
        (EXT_W'(1) <<< FRACTION_BITS) - EXT_W'(1);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DC_LO     = 4'd1;
    localparam logic [3:0] S_DC_HI     = 4'd2;
    localparam logic [3:0] S_DC_WAIT   = 4'd3;
    localparam logic [3:0] S_DC_END    = 4'd4;
    localparam logic [3:0] S_DIV_START = 4'd5;
    localparam logic [3:0] S_DIV       = 4'd6;
    localparam logic [3:0] S_MEAN      = 4'd7;
    localparam logic [3:0] S_LP_A      = 4'd8;
    localparam logic [3:0] S_LP_B      = 4'd9;
    localparam logic [3:0] S_LP_C      = 4'd10;
    localparam logic [3:0] S_LP_D      = 4'd11;
    localparam logic [3:0] S_LP_WAIT   = 4'd12;
    localparam logic [3:0] S_LP_END    = 4'd13;
    localparam logic [3:0] S_OUT       = 4'd14;

    function automatic logic signed [W_W-1:0] sat40(input logic signed [EXT_W-1:0] v);
        if ((&v[EXT_W-1:W_W-1]) || !(|v[EXT_W-1:W_W-1])) begin
            return v[W_W-1:0];
        end
        return v[EXT_W-1] ? {1'b1, {(W_W-1){1'b0}}} : {1'b0, {(W_W-1){1'b1}}};
    endfunction

    function automatic logic signed [D_W-1:0] sat36(input logic signed [EXT_W-1:0] v);
        if ((&v[EXT_W-1:D_W-1]) || !(|v[EXT_W-1:D_W-1])) begin
            return v[D_W-1:0];
        end
        return v[EXT_W-1] ? {1'b1, {(D_W-1){1'b0}}} : {1'b0, {(D_W-1){1'b1}}};
    endfunction

    function automatic logic signed [ppgf_pkg::OUT_W-1:0] sat24(
        input logic signed [EXT_W-1:0] v
    );
        if ((&v[EXT_W-1:ppgf_pkg::OUT_W-1]) || !(|v[EXT_W-1:ppgf_pkg::OUT_W-1])) begin
            return v[ppgf_pkg::OUT_W-1:0];
        end
        return v[EXT_W-1] ? {1'b1, {(ppgf_pkg::OUT_W-1){1'b0}}}
                          : {1'b0, {(ppgf_pkg::OUT_W-1){1'b1}}};
    endfunction

    logic [3:0] r_state;

    logic [ppgf_pkg::CFG_W-1:0] r_dc_alpha;
    logic [ppgf_pkg::CFG_W-1:0] r_lp_input_gain;
    logic [ppgf_pkg::CFG_W-1:0] r_lp_feedback;
    logic [ppgf_pkg::CFG_W-1:0] r_warmup_discard;

    logic signed [W_W-1:0]     r_x;
    logic signed [W_W-1:0]     r_dc;
    logic signed [D_W-1:0]     r_d;
    logic signed [TOTAL_W-1:0] r_total;
    logic        [FILL_W-1:0]  r_fill;
    logic signed [W_W-1:0]     r_m;
    logic signed [V_W-1:0]     r_lp;
    logic [ppgf_pkg::CNT_W-1:0] r_discard;
    logic signed [ppgf_pkg::OUT_W-1:0] r_y;
    logic                      r_emit;
    logic                      r_out_valid;
    logic signed [ppgf_pkg::OUT_W-1:0] r_out_value;

    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_prod_vld;
    logic                      r_prod_hi;
    logic signed [SUM_W-1:0]   r_acc;

    logic                      in_xfer;
    logic                      mul_issue;
    logic                      mul_hi;
    logic [ppgf_pkg::COEF_W-1:0] mul_coef;
    logic signed [W_W-1:0]     mul_opnd;
    logic signed [ppgf_pkg::MUL_A_W-1:0] mul_a;
    logic signed [ppgf_pkg::MUL_B_W-1:0] mul_b;
    logic signed [SUM_W-1:0]   addend;

    logic signed [EXT_W-1:0]   acc_q16;
    logic signed [W_W-1:0]     w_sat;
    logic signed [D_W-1:0]     d_sat;
    logic signed [TOTAL_W-1:0] total_next;
    logic signed [V_W-1:0]     v1_sat;
    logic signed [EXT_W-1:0]   lp_sum;
    logic signed [EXT_W-1:0]   lp_scaled;
    logic                      out_load;

    logic                      div_done;
    logic signed [TOTAL_W-1:0] div_quot;

    ppgf_pkg::t_d tap [MEAN_WINDOW+1];

    assign in_xfer = i_in_valid && o_in_ready;

    // window shift line
    assign tap[0] = d_sat;

    for (genvar gi = 0; gi < MEAN_WINDOW; gi++) begin : g_cell
        ppgf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (r_state == S_DC_END),
            .i_data  (tap[gi]),
            .o_data  (tap[gi+1])
        );
    end

    ppgf_div #(
        .NUM_W (TOTAL_W),
        .DEN_W (FILL_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIV_START),
        .i_num   (r_total),
        .i_den   (r_fill),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // shared multiplier operand select
    always_comb begin
        mul_issue = 1'b0;
        mul_hi    = 1'b0;
        mul_coef  = r_dc_alpha;
        mul_opnd  = r_dc;
        case (r_state)
            S_DC_LO: begin
                mul_issue = 1'b1;
            end
            S_DC_HI: begin
                mul_issue = 1'b1;
                mul_hi    = 1'b1;
            end
            S_LP_A: begin
                mul_issue = 1'b1;
                mul_coef  = r_lp_input_gain;
                mul_opnd  = r_m;
            end
            S_LP_B: begin
                mul_issue = 1'b1;
                mul_hi    = 1'b1;
                mul_coef  = r_lp_input_gain;
                mul_opnd  = r_m;
            end
            S_LP_C: begin
                mul_issue = 1'b1;
                mul_coef  = r_lp_feedback;
                mul_opnd  = W_W'(r_lp);
            end
            S_LP_D: begin
                mul_issue = 1'b1;
                mul_hi    = 1'b1;
                mul_coef  = r_lp_feedback;
                mul_opnd  = W_W'(r_lp);
            end
            default: begin
                mul_issue = 1'b0;
            end
        endcase
    end

    assign mul_a  = $signed({1'b0, mul_coef});
    assign mul_b  = mul_hi ? $signed({mul_opnd[W_W-1], mul_opnd[W_W-1:HALF_W]})
                           : $signed({1'b0, mul_opnd[HALF_W-1:0]});
    assign addend = r_prod_hi ? (SUM_W'(r_prod) <<< HALF_W) : SUM_W'(r_prod);

    // stage 1 and window update
    assign acc_q16    = $signed(r_acc[SUM_W-1:ppgf_pkg::COEF_FRAC]);
    assign w_sat      = sat40(EXT_W'(r_x) + acc_q16);
    assign d_sat      = sat36(EXT_W'(w_sat) - EXT_W'(r_dc));
    assign total_next = r_total - TOTAL_W'(tap[MEAN_WINDOW]) + TOTAL_W'(d_sat);

    // stage 3 and output scaling
    assign v1_sat    = sat36(acc_q16);
    assign lp_sum    = EXT_W'(r_lp) + EXT_W'(v1_sat);
    assign lp_scaled = (lp_sum + (lp_sum[EXT_W-1] ? ROUND_ADD : EXT_W'(0))) >>> FRACTION_BITS;

    assign out_load = (r_state == S_OUT) && r_emit && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc_alpha       <= ppgf_pkg::RST_DC_ALPHA;
            r_lp_input_gain  <= ppgf_pkg::RST_LP_INPUT_GAIN;
            r_lp_feedback    <= ppgf_pkg::RST_LP_FEEDBACK;
            r_warmup_discard <= ppgf_pkg::RST_WARMUP_DISCARD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ppgf_pkg::CFG_DC_ALPHA:       r_dc_alpha       <= i_cfg_data;
                ppgf_pkg::CFG_LP_INPUT_GAIN:  r_lp_input_gain  <= i_cfg_data;
                ppgf_pkg::CFG_LP_FEEDBACK:    r_lp_feedback    <= i_cfg_data;
                ppgf_pkg::CFG_WARMUP_DISCARD: r_warmup_discard <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dc        <= '0;
            r_total     <= '0;
            r_fill      <= '0;
            r_lp        <= '0;
            r_discard   <= '0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
            r_prod_vld  <= 1'b0;
            r_acc       <= '0;
        end else begin
            r_prod_vld <= mul_issue;
            if (r_state == S_DC_END || r_state == S_LP_END) begin
                r_acc <= '0;
            end else if (r_prod_vld) begin
                r_acc <= r_acc + addend;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_state <= S_DC_LO;
                    end
                end
                S_DC_LO:     r_state <= S_DC_HI;
                S_DC_HI:     r_state <= S_DC_WAIT;
                S_DC_WAIT:   r_state <= S_DC_END;
                S_DC_END: begin
                    r_dc    <= w_sat;
                    r_total <= total_next;
                    if (r_fill != FILL_W'(MEAN_WINDOW)) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_state <= S_DIV_START;
                end
                S_DIV_START: r_state <= S_DIV;
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_MEAN;
                    end
                end
                S_MEAN:      r_state <= S_LP_A;
                S_LP_A:      r_state <= S_LP_B;
                S_LP_B:      r_state <= S_LP_C;
                S_LP_C:      r_state <= S_LP_D;
                S_LP_D:      r_state <= S_LP_WAIT;
                S_LP_WAIT:   r_state <= S_LP_END;
                S_LP_END: begin
                    r_lp <= v1_sat;
                    if (r_discard < r_warmup_discard) begin
                        r_discard <= r_discard + 1'b1;
                        r_emit    <= 1'b0;
                    end else begin
                        r_emit <= 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_emit || out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_x <= W_W'(i_raw_sample) <<< FRACTION_BITS;
        end
        if (mul_issue) begin
            r_prod    <= mul_a * mul_b;
            r_prod_hi <= mul_hi;
        end
        if (r_state == S_DC_END) begin
            r_d <= d_sat;
        end
        if (r_state == S_MEAN) begin
            r_m <= W_W'(div_quot) - W_W'(r_d);
        end
        if (r_state == S_LP_END) begin
            r_y <= sat24(lp_scaled);
        end
        if (out_load) begin
            r_out_value <= r_y;
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_filtered_value = r_out_value;

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("output valid rose outside the output step");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_START) |-> (r_fill != '0 && r_fill <= FILL_W'(MEAN_WINDOW)))
        else $error("window fill out of range at divide start");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_DC_LO))
        else $error("input transfer did not start the sequence");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");

endmodule
